>>> hdl/ordered_array_insert_delete_core_assert.svh
// Assertion macros shared by the ordered list design files.
`ifndef ORDERED_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OAID_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ordered list check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OAID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ordered list check failed");

`endif

>>> hdl/oaid_pkg.sv
// Shared types and constants of the ordered list core.
package oaid_pkg;

  localparam int TYPE_W  = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_DEL_EQ = 3'd2,
    REQ_READ   = 3'd3,
    REQ_MODIFY = 3'd4
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_MOD,
    CMD_COMPACT
  } cell_cmd_e;

endpackage

>>> hdl/oaid_if.sv
// Request and response channel interfaces of the ordered list core.
interface oaid_req_if;
  logic                         valid;
  logic                         ready;
  logic [oaid_pkg::TYPE_W-1:0]  req_type;
  logic [oaid_pkg::POS_W-1:0]   position;
  logic [oaid_pkg::VALUE_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface oaid_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [oaid_pkg::STAT_W-1:0]  status;
  logic [oaid_pkg::VALUE_W-1:0] read_value;
  logic [oaid_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

>>> hdl/oaid_cell.sv
// One storage cell of the ordered list chain.
module oaid_cell #(
  parameter int DW    = 32,
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  logic                       clk_i,
  input  oaid_pkg::cell_cmd_e        cmd_i,
  input  logic [IW-1:0]              tgt_i,
  input  logic [DW-1:0]              word_i,
  input  logic [DW-1:0]              lower_i,
  input  logic [DW-1:0]              upper_i,
  output logic [DW-1:0]              data_o
);

  logic [DW-1:0] data_q, data_d;
  logic          at, above;

  always_comb begin
    at     = (tgt_i == IW'(INDEX));
    above  = (IW'(INDEX) > tgt_i);
    data_d = data_q;
    case (cmd_i)
      oaid_pkg::CMD_INS: begin
        if (above) begin
          data_d = lower_i;
        end else if (at) begin
          data_d = word_i;
        end
      end
      oaid_pkg::CMD_DEL: begin
        if (at || above) begin
          data_d = upper_i;
        end
      end
      oaid_pkg::CMD_MOD: begin
        if (at) begin
          data_d = word_i;
        end
      end
      oaid_pkg::CMD_COMPACT: begin
        // The head word is rotated into the tail slot while the rest moves down.
        data_d = at ? word_i : upper_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> hdl/ordered_array_insert_delete_core.sv
// Ordered list of words held in a chain of shifting cells, with its request sequencer.
// Insert, delete, read and modify give their result in the cycle after acceptance.
// Delete-all-equal walks the list once, one entry per cycle, before it gives its result.
// Throughput: one positional item per cycle while responses are taken; the head-rotation loop
// of delete-all-equal holds off new items until its walk ends.
// Reset: the entry count and handshake state clear at once; cell contents are not reset.
`include "ordered_array_insert_delete_core_assert.svh"

module ordered_array_insert_delete_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oaid_req_if.sink    req_i,
  oaid_rsp_if.source  rsp_o
);

  // Count needs to hold CAPACITY itself; cell indexes only reach CAPACITY - 1.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int WW = (CW > oaid_pkg::POS_W) ? CW : oaid_pkg::POS_W;

  typedef enum logic {S_IDLE, S_COMPACT} state_e;

  state_e                        state_q;
  logic [CW-1:0]                 count_q;
  logic [CW-1:0]                 n_q;      // live entries during compaction
  logic [CW-1:0]                 steps_q;  // head rotations still to do
  logic [DATA_WIDTH-1:0]         value_q;  // word being removed
  logic                          rsp_valid_q;
  logic                          rsp_valid_d;
  logic [oaid_pkg::STAT_W-1:0]   rsp_status_q;
  logic [oaid_pkg::VALUE_W-1:0]  rsp_value_q;
  logic [oaid_pkg::COUNT_W-1:0]  rsp_count_q;

  logic [DATA_WIDTH-1:0]         cell_data [CAPACITY];
  oaid_pkg::cell_cmd_e           cell_cmd;
  logic [IW-1:0]                 cell_tgt;
  logic [DATA_WIDTH-1:0]         cell_word;

  logic                          accept;
  logic [WW-1:0]                 pos_w, cnt_w;
  logic                          in_range;
  logic [DATA_WIDTH-1:0]         word_in;
  logic [oaid_pkg::STAT_W-1:0]   status_c;
  logic [CW-1:0]                 cnt_nxt;
  logic                          keep;
  logic [CW-1:0]                 n_nxt;
  logic [DATA_WIDTH-1:0]         rd_word;

  // A new item is taken only in idle and only when the response register is free
  // or being emptied in this same cycle.
  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // The response register loads when an item finishes, and otherwise holds its item
  // until the sink takes it. A compaction starts only once the register is free, so
  // its result never lands on a waiting one.
  assign rsp_valid_d = (accept &&
                        !((req_i.req_type == oaid_pkg::REQ_DEL_EQ) && (count_q != '0))) ||
                       ((state_q == S_COMPACT) && (steps_q == CW'(1))) ||
                       (rsp_valid_q && !rsp_o.ready);

  assign pos_w    = WW'(req_i.position);
  assign cnt_w    = WW'(count_q);
  assign in_range = (pos_w < cnt_w);
  assign word_in  = DATA_WIDTH'(req_i.value);
  assign rd_word  = cell_data[pos_w[IW-1:0]];

  // During compaction the head cell is examined each cycle: a kept word is
  // rotated to the tail of the live region, a matching word is dropped by a
  // plain shift down of the whole chain.
  assign keep  = (cell_data[0] != value_q);
  assign n_nxt = keep ? n_q : (n_q - 1'b1);

  always_comb begin
    cell_cmd  = oaid_pkg::CMD_HOLD;
    cell_tgt  = pos_w[IW-1:0];
    cell_word = word_in;
    status_c  = oaid_pkg::ST_ILLEGAL;
    cnt_nxt   = count_q;
    if (state_q == S_COMPACT) begin
      cell_word = cell_data[0];
      if (keep) begin
        cell_cmd = oaid_pkg::CMD_COMPACT;
        cell_tgt = IW'(n_q - 1'b1);
      end else begin
        cell_cmd = oaid_pkg::CMD_DEL;
        cell_tgt = '0;
      end
    end else if (accept) begin
      case (req_i.req_type)
        oaid_pkg::REQ_INSERT: begin
          // The position check takes precedence over the full check.
          if (pos_w > cnt_w) begin
            status_c = oaid_pkg::ST_ILLEGAL;
          end else if (count_q == CW'(CAPACITY)) begin
            status_c = oaid_pkg::ST_FULL;
          end else begin
            status_c = oaid_pkg::ST_OK;
            cell_cmd = oaid_pkg::CMD_INS;
            cnt_nxt  = count_q + 1'b1;
          end
        end
        oaid_pkg::REQ_DELETE: begin
          if (in_range) begin
            status_c = oaid_pkg::ST_OK;
            cell_cmd = oaid_pkg::CMD_DEL;
            cnt_nxt  = count_q - 1'b1;
          end
        end
        oaid_pkg::REQ_DEL_EQ: begin
          status_c = oaid_pkg::ST_OK;
        end
        oaid_pkg::REQ_READ: begin
          if (in_range) begin
            status_c = oaid_pkg::ST_OK;
          end
        end
        oaid_pkg::REQ_MODIFY: begin
          if (in_range) begin
            status_c = oaid_pkg::ST_OK;
            cell_cmd = oaid_pkg::CMD_MOD;
          end
        end
        default: begin
          status_c = oaid_pkg::ST_ILLEGAL;
        end
      endcase
    end
  end

  // The cell chain: each cell sees its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    oaid_cell #(
      .DW    (DATA_WIDTH),
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .tgt_i   (cell_tgt),
      .word_i  (cell_word),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      n_q          <= '0;
      steps_q      <= '0;
      value_q      <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_value_q  <= '0;
      rsp_count_q  <= '0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if ((req_i.req_type == oaid_pkg::REQ_DEL_EQ) && (count_q != '0)) begin
              state_q <= S_COMPACT;
              n_q     <= count_q;
              steps_q <= count_q;
              value_q <= word_in;
            end else begin
              rsp_status_q <= status_c;
              if ((req_i.req_type == oaid_pkg::REQ_READ) && in_range) begin
                rsp_value_q <= oaid_pkg::VALUE_W'(rd_word);
              end else begin
                rsp_value_q <= '0;
              end
              rsp_count_q  <= oaid_pkg::COUNT_W'(cnt_nxt);
              count_q      <= cnt_nxt;
            end
          end
        end
        S_COMPACT: begin
          steps_q <= steps_q - 1'b1;
          n_q     <= n_nxt;
          if (steps_q == CW'(1)) begin
            state_q      <= S_IDLE;
            count_q      <= n_nxt;
            rsp_status_q <= oaid_pkg::ST_OK;
            rsp_value_q  <= '0;
            rsp_count_q  <= oaid_pkg::COUNT_W'(n_nxt);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.entry_count = rsp_count_q;

  // The list never holds more entries than there are cells.
  `OAID_ASSERT_IMPL(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY))
  // While compacting, rotations remain and the live region never outgrows the count.
  `OAID_ASSERT_IMPL(a_compact_live, clk_i, rst_ni, state_q == S_COMPACT, (steps_q != '0) && (n_q <= count_q) && (steps_q <= n_q))
  // A successful insert grows the list by exactly one.
  `OAID_ASSERT_NEXT(a_insert_grow, clk_i, rst_ni, accept && (cell_cmd == oaid_pkg::CMD_INS), count_q == $past(count_q) + 1'b1)
  // A successful positional delete shrinks the list by exactly one.
  `OAID_ASSERT_NEXT(a_delete_shrink, clk_i, rst_ni, accept && (cell_cmd == oaid_pkg::CMD_DEL), count_q == $past(count_q) - 1'b1)

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ordered list core: a directed table, then random phases.
module testbench;

  localparam int CAPACITY     = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 950;
  // Slowest item: the longest sender gap, a full-list compaction walk and the longest
  // receiver stall. The limit is several times that over every item.
  localparam int CYCLE_LIMIT  = 400000;
  // A compaction of a full list is the longest the core can stay busy.
  localparam int DRAIN_CYCLES = CAPACITY + 16;
  localparam int N_DIRECTED   = 25;

  // Request codes the core does not define; it must answer them as illegal.
  localparam logic [oaid_pkg::TYPE_W-1:0] REQ_UNUSED_LO  = 3'd5;
  localparam logic [oaid_pkg::TYPE_W-1:0] REQ_UNUSED_MID = 3'd6;
  localparam logic [oaid_pkg::TYPE_W-1:0] REQ_UNUSED_HI  = 3'd7;

  typedef struct packed {
    oaid_pkg::status_e                status;
    logic [oaid_pkg::VALUE_W-1:0]     read_value;
    logic [oaid_pkg::COUNT_W-1:0]     entry_count;
  } rsp_t;

  typedef struct packed {
    logic [oaid_pkg::TYPE_W-1:0]      kind;
    logic [oaid_pkg::POS_W-1:0]       pos;
    logic [oaid_pkg::VALUE_W-1:0]     word;
    bit                               typed;
    rsp_t                             result;
  } stim_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} phase_e;

  localparam bit   TYPED = 1'b1;
  localparam bit   FREE  = 1'b0;
  localparam rsp_t NONE  = '{oaid_pkg::ST_OK, 32'h0, 7'd0};

  logic clk_i;
  logic rst_ni;

  oaid_req_if req_if ();
  oaid_rsp_if rsp_if ();

  ordered_array_insert_delete_core #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Predictor state: the list as the core should hold it.
  logic [oaid_pkg::VALUE_W-1:0] list_cells [CAPACITY];
  int                           list_count;

  rsp_t pending_results [$];
  int   error_count = 0;
  int   result_count = 0;
  int   sent_items;
  int   status_seen [3] = '{0, 0, 0};
  int   peak_count = 0;
  int   cycle_count = 0;
  bit   calm_phase;

  logic [oaid_pkg::VALUE_W-1:0] word_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h8000_0001, 32'h0000_00A5};

  // Directed table. Rows marked TYPED carry a result that can be read off at a glance;
  // the others take the predictor's result.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{oaid_pkg::REQ_READ,   7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd0}},
    '{oaid_pkg::REQ_DELETE, 7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd0}},
    '{oaid_pkg::REQ_MODIFY, 7'd0,   32'hDEAD_BEEF, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd0}},
    '{oaid_pkg::REQ_INSERT, 7'd1,   32'h0000_0001, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd0}},
    '{oaid_pkg::REQ_DEL_EQ, 7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_OK,      32'h0, 7'd0}},
    '{REQ_UNUSED_LO,        7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd0}},
    '{REQ_UNUSED_HI,        7'd127, 32'hFFFF_FFFF, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd0}},
    '{oaid_pkg::REQ_INSERT, 7'd0,   32'hFFFF_FFFF, TYPED, '{oaid_pkg::ST_OK,      32'h0, 7'd1}},
    '{oaid_pkg::REQ_INSERT, 7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_OK,      32'h0, 7'd2}},
    '{oaid_pkg::REQ_INSERT, 7'd2,   32'h5A5A_5A5A, TYPED, '{oaid_pkg::ST_OK,      32'h0, 7'd3}},
    '{oaid_pkg::REQ_INSERT, 7'd127, 32'h0000_0001, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd3}},
    '{oaid_pkg::REQ_INSERT, 7'd4,   32'h0000_0001, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd3}},
    '{oaid_pkg::REQ_READ,   7'd1,   32'h0000_0000, TYPED, '{oaid_pkg::ST_OK, 32'hFFFF_FFFF, 7'd3}},
    '{oaid_pkg::REQ_READ,   7'd2,   32'h0000_0000, FREE,  NONE},
    '{oaid_pkg::REQ_READ,   7'd3,   32'h0000_0000, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd3}},
    '{oaid_pkg::REQ_MODIFY, 7'd1,   32'h1234_5678, TYPED, '{oaid_pkg::ST_OK,      32'h0, 7'd3}},
    '{oaid_pkg::REQ_MODIFY, 7'd3,   32'hFFFF_FFFF, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd3}},
    '{oaid_pkg::REQ_INSERT, 7'd1,   32'h0000_0000, FREE,  NONE},
    '{oaid_pkg::REQ_DEL_EQ, 7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_OK,      32'h0, 7'd2}},
    '{oaid_pkg::REQ_DEL_EQ, 7'd0,   32'hFFFF_FFFF, FREE,  NONE},
    '{oaid_pkg::REQ_DELETE, 7'd2,   32'h0000_0000, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd2}},
    '{oaid_pkg::REQ_DELETE, 7'd0,   32'h0000_0000, FREE,  NONE},
    '{oaid_pkg::REQ_READ,   7'd0,   32'h0000_0000, FREE,  NONE},
    '{REQ_UNUSED_MID,       7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_ILLEGAL, 32'h0, 7'd1}},
    '{oaid_pkg::REQ_DELETE, 7'd0,   32'h0000_0000, TYPED, '{oaid_pkg::ST_OK,      32'h0, 7'd0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one request to the predicted list and returns the result it should give.
  function automatic rsp_t apply_request(input logic [oaid_pkg::TYPE_W-1:0] kind,
                                         input logic [oaid_pkg::POS_W-1:0] pos,
                                         input logic [oaid_pkg::VALUE_W-1:0] word);
    rsp_t res;
    int   wr;
    res = '{oaid_pkg::ST_OK, '0, '0};
    case (kind)
      oaid_pkg::REQ_INSERT: begin
        // A position past the end is checked before a full list.
        if (pos > list_count) begin
          res.status = oaid_pkg::ST_ILLEGAL;
        end else if (list_count >= CAPACITY) begin
          res.status = oaid_pkg::ST_FULL;
        end else begin
          for (int i = list_count; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = word;
          list_count++;
        end
      end
      oaid_pkg::REQ_DELETE: begin
        if (pos >= list_count) begin
          res.status = oaid_pkg::ST_ILLEGAL;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
          list_count--;
        end
      end
      oaid_pkg::REQ_DEL_EQ: begin
        // Keeps the order of the survivors; succeeds even when nothing matches.
        wr = 0;
        for (int i = 0; i < list_count; i++) begin
          if (list_cells[i] != word) begin
            list_cells[wr] = list_cells[i];
            wr++;
          end
        end
        list_count = wr;
      end
      oaid_pkg::REQ_READ: begin
        if (pos >= list_count) res.status = oaid_pkg::ST_ILLEGAL;
        else res.read_value = list_cells[pos];
      end
      oaid_pkg::REQ_MODIFY: begin
        if (pos >= list_count) res.status = oaid_pkg::ST_ILLEGAL;
        else list_cells[pos] = word;
      end
      default: res.status = oaid_pkg::ST_ILLEGAL;
    endcase
    res.entry_count = list_count[oaid_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic logic [oaid_pkg::VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 4))
      0: return word_pool[$urandom_range(0, 3)];
      1: return (list_count > 0) ? list_cells[$urandom_range(0, list_count - 1)] : $urandom();
      2: return $urandom_range(0, 1) ? '0 : '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [oaid_pkg::POS_W-1:0] live_pos();
    return (list_count == 0) ? '0 : oaid_pkg::POS_W'($urandom_range(0, list_count - 1));
  endfunction

  // Just out of range, or anywhere in the field.
  function automatic logic [oaid_pkg::POS_W-1:0] stray_pos();
    return $urandom_range(0, 1) ? oaid_pkg::POS_W'(list_count + $urandom_range(0, 3))
                                : oaid_pkg::POS_W'($urandom_range(0, 127));
  endfunction

  // Draws one request. Fill and drain phases are mostly well-formed, noise is not.
  task automatic gen_request(input phase_e kind,
                             output logic [oaid_pkg::TYPE_W-1:0] req_type,
                             output logic [oaid_pkg::POS_W-1:0] pos,
                             output logic [oaid_pkg::VALUE_W-1:0] word);
    int r;
    r = $urandom_range(0, 9);
    word = pick_word();
    case (kind)
      PH_FILL: begin
        if (r < 8) begin
          req_type = oaid_pkg::REQ_INSERT;
          // Once full, insert anywhere: at or below the count reports full, above it illegal.
          pos = (list_count == CAPACITY) ? oaid_pkg::POS_W'($urandom_range(0, 127))
                                         : oaid_pkg::POS_W'($urandom_range(0, list_count));
        end else begin
          req_type = (r == 8) ? oaid_pkg::REQ_READ : oaid_pkg::REQ_MODIFY;
          pos = live_pos();
        end
      end
      PH_DRAIN: begin
        if (r < 5) req_type = oaid_pkg::REQ_DELETE;
        else if (r < 7) req_type = oaid_pkg::REQ_DEL_EQ;
        else if (r < 9) req_type = oaid_pkg::REQ_READ;
        else req_type = oaid_pkg::REQ_MODIFY;
        pos = live_pos();
        if (req_type == oaid_pkg::REQ_DEL_EQ && list_count > 0)
          word = list_cells[$urandom_range(0, list_count - 1)];
      end
      PH_MIX: begin
        case ($urandom_range(0, 4))
          0: req_type = oaid_pkg::REQ_INSERT;
          1: req_type = oaid_pkg::REQ_DELETE;
          2: req_type = oaid_pkg::REQ_DEL_EQ;
          3: req_type = oaid_pkg::REQ_READ;
          default: req_type = oaid_pkg::REQ_MODIFY;
        endcase
        if (r == 0) pos = stray_pos();
        else if (req_type == oaid_pkg::REQ_INSERT)
          pos = oaid_pkg::POS_W'($urandom_range(0, list_count));
        else pos = live_pos();
      end
      default: begin
        req_type = oaid_pkg::TYPE_W'($urandom_range(0, 7));
        pos = oaid_pkg::POS_W'($urandom_range(0, 127));
        word = $urandom();
      end
    endcase
  endtask

  // Offers one item after a random gap, waits for it to be taken and records its result.
  task automatic send_req(input logic [oaid_pkg::TYPE_W-1:0] kind,
                          input logic [oaid_pkg::POS_W-1:0] pos,
                          input logic [oaid_pkg::VALUE_W-1:0] word, input bit typed,
                          input rsp_t given);
    int   gap;
    rsp_t predicted;
    gap = calm_phase ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.position <= pos;
    req_if.value    <= word;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted = apply_request(kind, pos, word);
    pending_results.push_back(typed ? given : predicted);
    sent_items++;
  endtask

  task automatic report_mismatch(input string field, input logic [oaid_pkg::VALUE_W-1:0] got,
                                 input logic [oaid_pkg::VALUE_W-1:0] want);
    $display("MISMATCH result %0d %s: got %0h, expected %0h", result_count, field, got, want);
    error_count++;
  endtask

  // Result side: random stalls, then every taken item is checked against the oldest
  // expectation.
  initial begin
    int   stall;
    rsp_t want;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm_phase ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, status", 32'(rsp_if.status), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.read_value !== want.read_value)
          report_mismatch("read_value", rsp_if.read_value, want.read_value);
        if (rsp_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp_if.entry_count), 32'(want.entry_count));
        if (want.status <= oaid_pkg::ST_FULL) status_seen[want.status]++;
        if (int'(want.entry_count) > peak_count) peak_count = want.entry_count;
      end
      result_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    phase_e                       phase;
    logic [oaid_pkg::TYPE_W-1:0]  kind;
    logic [oaid_pkg::POS_W-1:0]   pos;
    logic [oaid_pkg::VALUE_W-1:0] word;
    int                           random_sent;
    int                           phase_len;
    int                           n;
    int                           extra_full;
    bit                           phase_done;

    sent_items   = 0;
    random_sent  = 0;
    calm_phase   = 1'b0;
    list_count   = 0;

    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= oaid_pkg::REQ_INSERT;
    req_if.position <= '0;
    req_if.value    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_req(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].word,
               directed_rows[i].typed, directed_rows[i].result);

    // Random phases. A fill phase runs until the list is full and then keeps inserting
    // for a few items, so the full and past-the-end cases come up at capacity.
    while (random_sent < RANDOM_ITEMS) begin
      phase      = phase_e'($urandom_range(0, 3));
      calm_phase = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(30, 60);
      extra_full = 6;
      n          = 0;
      phase_done = 1'b0;
      while (!phase_done && random_sent < RANDOM_ITEMS && n < 130) begin
        if (phase == PH_FILL) begin
          if (list_count == CAPACITY) begin
            if (extra_full == 0) phase_done = 1'b1;
            else extra_full--;
          end
        end else if (n >= phase_len) begin
          phase_done = 1'b1;
        end
        if (!phase_done) begin
          gen_request(phase, kind, pos, word);
          send_req(kind, pos, word, FREE, NONE);
          random_sent++;
          n++;
        end
      end
    end
    req_if.valid <= 1'b0;
    calm_phase   = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d from the table) in %0d cycles; peak list size %0d of %0d.",
             sent_items, N_DIRECTED, cycle_count, peak_count, CAPACITY);
    $display("Results ok %0d, illegal position %0d, list full %0d; mismatches %0d.",
             status_seen[oaid_pkg::ST_OK], status_seen[oaid_pkg::ST_ILLEGAL],
             status_seen[oaid_pkg::ST_FULL], error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
